// File: rtl/btps_pkg.sv
package btps_pkg;

    // Pattern lengths.
    localparam int BEEP_COUNT = 3;
    localparam int NOTE_COUNT = 8;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int FREQ_W   = 15;
    localparam int HZ_W     = 16;
    localparam int BEEP_W   = 2;
    localparam int NOTE_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STOP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP   = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] BEEP_PERIOD_RST  = 16'd150;
    localparam logic [PERIOD_W-1:0] SWEEP_PERIOD_RST = 16'd20;
    localparam logic [PERIOD_W-1:0] NOTE_PERIOD_RST  = 16'd250;
    localparam logic [FREQ_W-1:0]   BEEP_BASE_RST    = 15'd2000;
    localparam logic [FREQ_W-1:0]   BEEP_STEP_RST    = 15'd400;
    localparam logic [FREQ_W-1:0]   SWEEP_START_RST  = 15'd400;
    localparam logic [FREQ_W-1:0]   SWEEP_STOP_RST   = 15'd3000;
    localparam logic [FREQ_W-1:0]   SWEEP_STEP_RST   = 15'd100;

    localparam logic [HZ_W-1:0] HZ_MAX = 16'hFFFF;

    typedef struct packed {
        logic [PERIOD_W-1:0] beep_period_ms;
        logic [PERIOD_W-1:0] sweep_period_ms;
        logic [PERIOD_W-1:0] note_period_ms;
        logic [FREQ_W-1:0]   beep_base_hz;
        logic [FREQ_W-1:0]   beep_step_hz;
        logic [FREQ_W-1:0]   sweep_start_hz;
        logic [FREQ_W-1:0]   sweep_stop_hz;
        logic [FREQ_W-1:0]   sweep_step_hz;
    } cfg_t;

    typedef struct packed {
        logic            tone_write;
        logic [HZ_W-1:0] tone_hz;
    } result_t;

    // Eight-note melody table.
    function automatic logic [HZ_W-1:0] melody_note(input logic [2:0] idx);
        logic [HZ_W-1:0] hz;
        case (idx)
            3'd0:    hz = 16'd262;
            3'd1:    hz = 16'd294;
            3'd2:    hz = 16'd330;
            3'd3:    hz = 16'd349;
            3'd4:    hz = 16'd392;
            3'd5:    hz = 16'd440;
            3'd6:    hz = 16'd494;
            3'd7:    hz = 16'd523;
            default: hz = 16'd0;
        endcase
        return hz;
    endfunction

endpackage

// File: rtl/buzzer_tone_pattern_sequencer_top.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   now_ms
// result    out        out_valid / out_stall tone_write, tone_hz
// config    in         cfg_write             cfg_index, cfg_data
//
// A tick transfer lands in an input register. When the output register can take
// a new result, the phase logic evaluates the tick against the sequencer state
// and loads the result into the output register, which then offers it to the
// receiver on the result channel.
// One tick is taken every cycle; the output register only blocks the input
// when it holds a result that the receiver is stalling.
// Reset is asynchronous and active low; it restores the register defaults and
// starts the pattern in the first beep with a time mark of zero.
module buzzer_tone_pattern_sequencer_top
    import btps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  tone_write,
    output logic [HZ_W-1:0]       tone_hz,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    result_t           result;

    logic              in_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg;
    logic              tone_write_reg;
    logic [HZ_W-1:0]   tone_hz_reg;

    logic              advance;
    logic              step;
    logic              in_take;

    // The output register can take a new result when it is empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    btps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    btps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .now_ms (now_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register: it holds its tick while the output side is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg <= now_ms;
        end
    end

    // Output register: loaded whenever the evaluated tick moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tone_write_reg <= result.tone_write;
            tone_hz_reg    <= result.tone_hz;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tone_write = tone_write_reg;
    assign tone_hz    = tone_hz_reg;

endmodule

// File: rtl/btps_cfg_regs.sv
module btps_cfg_regs
    import btps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beep_period_ms  <= BEEP_PERIOD_RST;
            cfg_reg.sweep_period_ms <= SWEEP_PERIOD_RST;
            cfg_reg.note_period_ms  <= NOTE_PERIOD_RST;
            cfg_reg.beep_base_hz    <= BEEP_BASE_RST;
            cfg_reg.beep_step_hz    <= BEEP_STEP_RST;
            cfg_reg.sweep_start_hz  <= SWEEP_START_RST;
            cfg_reg.sweep_stop_hz   <= SWEEP_STOP_RST;
            cfg_reg.sweep_step_hz   <= SWEEP_STEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BEEP_PERIOD:  cfg_reg.beep_period_ms  <= cfg_data;
                REG_SWEEP_PERIOD: cfg_reg.sweep_period_ms <= cfg_data;
                REG_NOTE_PERIOD:  cfg_reg.note_period_ms  <= cfg_data;
                REG_BEEP_BASE:    cfg_reg.beep_base_hz    <= cfg_data[FREQ_W-1:0];
                REG_BEEP_STEP:    cfg_reg.beep_step_hz    <= cfg_data[FREQ_W-1:0];
                REG_SWEEP_START:  cfg_reg.sweep_start_hz  <= cfg_data[FREQ_W-1:0];
                REG_SWEEP_STOP:   cfg_reg.sweep_stop_hz   <= cfg_data[FREQ_W-1:0];
                REG_SWEEP_STEP:   cfg_reg.sweep_step_hz   <= cfg_data[FREQ_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/btps_core.sv
module btps_core
    import btps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    output result_t           result
);

    typedef enum logic [1:0] {
        PH_BEEP  = 2'd0,
        PH_GAP   = 2'd1,
        PH_SWEEP = 2'd2,
        PH_MELODY = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   last_change_reg, last_change_next;
    logic [BEEP_W-1:0]   beep_index_reg, beep_index_next;
    logic [HZ_W-1:0]     sweep_hz_reg, sweep_hz_next;
    logic [NOTE_W-1:0]   note_index_reg, note_index_next;

    logic [TIME_W-1:0]   elapsed;
    logic                beep_over, sweep_over, note_over;
    logic [16:0]         beep_prod;
    logic [17:0]         beep_sum;
    logic [HZ_W-1:0]     beep_hz;

    assign elapsed    = now_ms - last_change_reg;
    assign beep_over  = elapsed > {{(TIME_W-PERIOD_W){1'b0}}, cfg.beep_period_ms};
    assign sweep_over = elapsed > {{(TIME_W-PERIOD_W){1'b0}}, cfg.sweep_period_ms};
    assign note_over  = elapsed > {{(TIME_W-PERIOD_W){1'b0}}, cfg.note_period_ms};

    // Beep frequency rises by one step per beep and saturates at the 16-bit limit.
    assign beep_prod = 17'(beep_index_reg * cfg.beep_step_hz);
    assign beep_sum  = {3'b000, cfg.beep_base_hz} + {1'b0, beep_prod};
    assign beep_hz   = (beep_sum > {2'b00, HZ_MAX}) ? HZ_MAX : beep_sum[HZ_W-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        last_change_next = last_change_reg;
        beep_index_next  = beep_index_reg;
        sweep_hz_next    = sweep_hz_reg;
        note_index_next  = note_index_reg;
        result.tone_write = 1'b0;
        result.tone_hz    = '0;

        case (phase_reg)
            PH_BEEP:
            begin
                if (beep_index_reg < BEEP_W'(BEEP_COUNT))
                begin
                    result.tone_write = 1'b1;
                    result.tone_hz    = beep_hz;
                    if (beep_over)
                    begin
                        // The beep ends in this tick, so the last command is silence.
                        result.tone_hz   = '0;
                        last_change_next = now_ms;
                        phase_next       = PH_GAP;
                        beep_index_next  = beep_index_reg + 1'b1;
                    end
                end
                else
                begin
                    beep_index_next  = '0;
                    phase_next       = PH_SWEEP;
                    last_change_next = now_ms;
                end
            end
            PH_GAP:
            begin
                if (beep_over)
                begin
                    last_change_next = now_ms;
                    phase_next       = PH_BEEP;
                end
            end
            PH_SWEEP:
            begin
                result.tone_write = 1'b1;
                if (sweep_hz_reg <= {1'b0, cfg.sweep_stop_hz})
                begin
                    result.tone_hz = sweep_hz_reg;
                    if (sweep_over)
                    begin
                        sweep_hz_next    = sweep_hz_reg + {1'b0, cfg.sweep_step_hz};
                        last_change_next = now_ms;
                    end
                end
                else
                begin
                    sweep_hz_next    = {1'b0, cfg.sweep_start_hz};
                    phase_next       = PH_MELODY;
                    last_change_next = now_ms;
                end
            end
            PH_MELODY:
            begin
                result.tone_write = 1'b1;
                if (note_index_reg < NOTE_W'(NOTE_COUNT))
                begin
                    result.tone_hz = melody_note(note_index_reg[2:0]);
                    if (note_over)
                    begin
                        note_index_next  = note_index_reg + 1'b1;
                        last_change_next = now_ms;
                    end
                end
                else
                begin
                    // The melody wraps back to the beeps without a new time mark.
                    note_index_next = '0;
                    phase_next      = PH_BEEP;
                end
            end
            default:
            begin
                phase_next = PH_BEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BEEP;
            last_change_reg <= '0;
            beep_index_reg  <= '0;
            sweep_hz_reg    <= {1'b0, SWEEP_START_RST};
            note_index_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            last_change_reg <= last_change_next;
            beep_index_reg  <= beep_index_next;
            sweep_hz_reg    <= sweep_hz_next;
            note_index_reg  <= note_index_next;
        end
    end

endmodule
